// File: rtl/gregorian_date_adder_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the Gregorian date adder
// Concurrent checks that compile away when ASSERT_OFF is defined.
// -----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADDER_ASSERT_SVH
`define GREGORIAN_DATE_ADDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GDA_ASSERT_IMP(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) \
    else $error("gregorian_date_adder check failed");
`define GDA_ASSERT_AFTER(lbl, clk_s, a, c) \
  lbl: assert property (@(posedge clk_s) (a) |=> (c)) \
    else $error("gregorian_date_adder check failed");
`else
`define GDA_ASSERT_IMP(lbl, clk_s, rst_s, a, c)
`define GDA_ASSERT_AFTER(lbl, clk_s, a, c)
`endif
`endif

// File: rtl/gda_pkg.sv
// -----------------------------------------------------------------------------
// Gregorian date adder package
// Codes, division constants, calendar tables and the pipeline record.
// -----------------------------------------------------------------------------
package gda_pkg;

  localparam logic [1:0] KIND_DAYS   = 2'd0;
  localparam logic [1:0] KIND_MONTHS = 2'd1;
  localparam logic [1:0] KIND_YEARS  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EARLY   = 2'd1,
    ST_LATE    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  localparam int M_Y100   = 163;
  localparam int M_R100   = 655;
  localparam int M_U12    = 349525;
  localparam int M_N400   = 57;
  localparam int M_R1461  = 44;
  localparam int DAYS_400 = 146097;
  localparam int DAYS_100 = 36524;
  localparam int DAYS_4   = 1461;
  localparam int DAYS_1   = 365;
  localparam int MONTH_OFF = 131072;
  localparam int U12_BIAS  = 1572864;

  function automatic logic leap_of(logic [1:0] ylow, logic [6:0] r100, logic [1:0] qlow);
    return ((ylow == 2'd0) && (r100 != 7'd0)) || ((r100 == 7'd0) && (qlow == 2'd0));
  endfunction

  function automatic logic [8:0] cum_days(logic [3:0] mon, logic leap);
    logic [8:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon > 4'd2) && (mon <= 4'd12)) base = base + 9'd1;
    return base;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] len;
    case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         m;
    logic [4:0]         d;
    logic [13:0]        y;
    logic signed [20:0] amt;
    logic [21:0]        u;
    logic [7:0]         q100s;
    logic [6:0]         r100s;
    logic [17:0]        q12;
    logic [3:0]         r12;
    logic [22:0]        yearpart;
    logic [8:0]         dpart;
    logic signed [21:0] ty;
    logic [3:0]         tm;
    logic signed [23:0] n;
    status_t            st;
    logic [5:0]         q400;
    logic [17:0]        r400;
    logic [1:0]         q100d;
    logic [15:0]        r1;
    logic [4:0]         q4;
    logic [10:0]        r2;
    logic [1:0]         q1;
    logic [8:0]         r3;
    logic [15:0]        ry;
    logic [9:0]         q100r;
    logic [6:0]         r100r;
  } pipe_t;

endpackage

// File: rtl/gda_month_split.sv
// -----------------------------------------------------------------------------
// Month split
// Turns a zero-based day of year into month and day of month.
// -----------------------------------------------------------------------------
module gda_month_split (
  input  logic [8:0] doy,
  input  logic       leap,
  output logic [3:0] month,
  output logic [4:0] day
);
  import gda_pkg::*;

  logic [8:0] base;

  always_comb begin
    month = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy >= cum_days(4'(k), leap)) month = 4'(k);
    end
    base = doy - cum_days(month, leap);
    day  = 5'(base + 9'd1);
  end

endmodule

// File: rtl/gregorian_date_adder.sv
// -----------------------------------------------------------------------------
// Gregorian date adder
// Adds a signed number of days, months or years to a Gregorian date (kind 3 leaves it unchanged).
// -----------------------------------------------------------------------------
// Input transactions carry the start date and amount on s_tdata and the kind
// of addition on s_tuser. Output transactions carry the resulting date on
// m_tdata and the status on m_tuser, one result per input, in order.
// The datapath is a 14-stage pipeline; each stage holds about one constant
// multiply or one wide add and compare (divides by 100, 12, 146097 and 1461
// are reciprocal multiplies followed by one correction stage).
// The block takes one transaction per cycle while the output is not stalled.
// When the receiver stalls the whole pipeline holds, and s_tready drops
// until the output register is taken.
// Reset (rst, synchronous) clears all stage valid bits; the pipeline is empty
// and ready in the cycle after reset is released.
// -----------------------------------------------------------------------------
`include "gregorian_date_adder_assert.svh"

module gregorian_date_adder #(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_month[3:0], start_day[8:4], start_year[22:9], amount[43:23], zero pad
  input  logic [47:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_month[3:0], result_day[8:4], result_year[22:9], zero pad
  output logic [23:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser
);
  import gda_pkg::*;

  localparam int NS = 14;
  localparam int LAST_DAY = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                            + MAX_YEAR / 400 - 1;

  pipe_t p [1:NS];
  pipe_t c [1:NS];
  logic  v [1:NS];
  logic  en;
  logic  leap13;
  logic [3:0] split_m;
  logic [4:0] split_d;

  assign en       = !v[NS] || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[NS];
  assign m_tdata  = {1'b0, p[NS].ry[13:0], p[NS].d, p[NS].m};
  assign m_tuser  = p[NS].st;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[1] <= s_tvalid;
      for (int k = 2; k <= NS; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NS; k++) p[k] <= c[k];
    end
  end

  always_comb begin
    logic [22:0] amt_x;
    amt_x = {{2{s_tdata[43]}}, s_tdata[43:23]};
    c[1]       = '0;
    c[1].kind  = s_tuser;
    c[1].m     = s_tdata[3:0];
    c[1].d     = s_tdata[8:4];
    c[1].y     = s_tdata[22:9];
    c[1].amt   = $signed(s_tdata[43:23]);
    c[1].u     = 22'(23'(s_tdata[22:9]) * 23'd12 + 23'(s_tdata[3:0]) - 23'd1 + amt_x
                     + 23'(U12_BIAS));
    c[1].ty    = $signed({8'd0, s_tdata[22:9]}) + $signed({s_tdata[43], s_tdata[43:23]});
    c[1].q100s = 8'((22'(s_tdata[22:9]) * 22'(M_Y100)) >> 14);
  end

  always_comb begin
    logic [13:0] t;
    c[2] = p[1];
    t = p[1].y - 14'(16'(p[1].q100s) * 16'd100);
    if (t >= 14'd100) begin
      c[2].q100s = p[1].q100s + 8'd1;
      t = t - 14'd100;
    end
    c[2].r100s = 7'(t);
    c[2].q12   = 18'((41'(p[1].u) * 41'(M_U12)) >> 22);
  end

  always_comb begin
    logic [21:0] t;
    logic [13:0] py;
    logic [7:0]  p100;
    logic        lp;
    c[3] = p[2];
    lp = leap_of(p[2].y[1:0], p[2].r100s, p[2].q100s[1:0]);
    py   = p[2].y - 14'd1;
    p100 = p[2].q100s - ((p[2].r100s == 7'd0) ? 8'd1 : 8'd0);
    c[3].yearpart = 23'(py) * 23'd365 + 23'(py >> 2) - 23'(p100) + 23'(p100 >> 2);
    c[3].dpart    = cum_days(p[2].m, lp) + 9'(p[2].d) - 9'd1;
    if ((p[2].m < 4'd1) || (p[2].m > 4'd12) || (p[2].y == 14'd0)
        || (17'(p[2].y) > 17'(MAX_YEAR)) || (p[2].d == 5'd0)
        || (p[2].d > month_len(p[2].m, lp))) begin
      c[3].st = ST_INVALID;
    end else begin
      c[3].st = ST_OK;
    end
    t = p[2].u - 22'(22'(p[2].q12) * 22'd12);
    if (t >= 22'd12) begin
      c[3].q12 = p[2].q12 + 18'd1;
      t = t - 22'd12;
    end
    c[3].r12 = 4'(t);
  end

  always_comb begin
    c[4] = p[3];
    c[4].n = $signed({1'b0, p[3].yearpart}) + $signed({15'd0, p[3].dpart})
             + $signed({{3{p[3].amt[20]}}, p[3].amt});
    case (p[3].kind)
      KIND_MONTHS: begin
        c[4].ty = $signed({4'd0, p[3].q12}) - 22'(MONTH_OFF);
        c[4].tm = p[3].r12 + 4'd1;
      end
      KIND_YEARS: begin
        c[4].tm = p[3].m;
      end
      default: begin
        c[4].ty = $signed({8'd0, p[3].y});
        c[4].tm = p[3].m;
      end
    endcase
  end

  always_comb begin
    c[5] = p[4];
    if (p[4].st == ST_OK) begin
      if (p[4].kind == KIND_DAYS) begin
        if (p[4].n[23]) c[5].st = ST_EARLY;
        else if (25'(p[4].n[22:0]) > 25'(LAST_DAY)) c[5].st = ST_LATE;
      end else begin
        if (p[4].ty[21] || (p[4].ty == 22'sd0)) c[5].st = ST_EARLY;
        else if (22'(p[4].ty) > 22'(MAX_YEAR)) c[5].st = ST_LATE;
      end
    end
    c[5].q400 = 6'((29'(p[4].n[22:0]) * 29'(M_N400)) >> 23);
  end

  always_comb begin
    logic [22:0] t;
    c[6] = p[5];
    t = p[5].n[22:0] - 23'(23'(p[5].q400) * 23'(DAYS_400));
    if (t >= 23'(DAYS_400)) begin
      c[6].q400 = p[5].q400 + 6'd1;
      t = t - 23'(DAYS_400);
    end
    c[6].r400 = 18'(t);
  end

  always_comb begin
    c[7] = p[6];
    if (p[6].r400 >= 18'(3 * DAYS_100)) begin
      c[7].q100d = 2'd3;
      c[7].r1    = 16'(p[6].r400 - 18'(3 * DAYS_100));
    end else if (p[6].r400 >= 18'(2 * DAYS_100)) begin
      c[7].q100d = 2'd2;
      c[7].r1    = 16'(p[6].r400 - 18'(2 * DAYS_100));
    end else if (p[6].r400 >= 18'(DAYS_100)) begin
      c[7].q100d = 2'd1;
      c[7].r1    = 16'(p[6].r400 - 18'(DAYS_100));
    end else begin
      c[7].q100d = 2'd0;
      c[7].r1    = 16'(p[6].r400);
    end
  end

  always_comb begin
    c[8] = p[7];
    c[8].q4 = 5'((22'(p[7].r1) * 22'(M_R1461)) >> 16);
  end

  always_comb begin
    logic [15:0] t;
    c[9] = p[8];
    t = p[8].r1 - 16'(16'(p[8].q4) * 16'(DAYS_4));
    if (t >= 16'(DAYS_4)) begin
      c[9].q4 = p[8].q4 + 5'd1;
      t = t - 16'(DAYS_4);
    end
    c[9].r2 = 11'(t);
  end

  always_comb begin
    c[10] = p[9];
    if (p[9].r2 >= 11'(3 * DAYS_1)) begin
      c[10].q1 = 2'd3;
      c[10].r3 = 9'(p[9].r2 - 11'(3 * DAYS_1));
    end else if (p[9].r2 >= 11'(2 * DAYS_1)) begin
      c[10].q1 = 2'd2;
      c[10].r3 = 9'(p[9].r2 - 11'(2 * DAYS_1));
    end else if (p[9].r2 >= 11'(DAYS_1)) begin
      c[10].q1 = 2'd1;
      c[10].r3 = 9'(p[9].r2 - 11'(DAYS_1));
    end else begin
      c[10].q1 = 2'd0;
      c[10].r3 = 9'(p[9].r2);
    end
  end

  always_comb begin
    c[11] = p[10];
    if (p[10].kind == KIND_DAYS) begin
      c[11].ry = 16'(p[10].q400) * 16'd400 + 16'(p[10].q100d) * 16'd100
                 + 16'(p[10].q4) * 16'd4 + 16'(p[10].q1) + 16'd1;
    end else begin
      c[11].ry = 16'(p[10].ty);
    end
  end

  always_comb begin
    c[12] = p[11];
    c[12].q100r = 10'((32'(p[11].ry) * 32'(M_R100)) >> 16);
  end

  always_comb begin
    logic [15:0] t;
    c[13] = p[12];
    t = p[12].ry - 16'(16'(p[12].q100r) * 16'd100);
    if (t >= 16'd100) begin
      c[13].q100r = p[12].q100r + 10'd1;
      t = t - 16'd100;
    end
    c[13].r100r = 7'(t);
  end

  assign leap13 = leap_of(p[13].ry[1:0], p[13].r100r, p[13].q100r[1:0]);

  gda_month_split u_split (
    .doy   (p[13].r3),
    .leap  (leap13),
    .month (split_m),
    .day   (split_d)
  );

  always_comb begin
    logic [4:0] len;
    c[14] = p[13];
    len = month_len(p[13].tm, leap13);
    case (p[13].st)
      ST_INVALID: begin
        c[14].m  = 4'd0;
        c[14].d  = 5'd0;
        c[14].ry = 16'd0;
      end
      ST_EARLY: begin
        c[14].m  = 4'd1;
        c[14].d  = 5'd1;
        c[14].ry = 16'd1;
      end
      ST_LATE: begin
        c[14].m  = 4'd12;
        c[14].d  = 5'd31;
        c[14].ry = 16'(MAX_YEAR);
      end
      default: begin
        if (p[13].kind == KIND_DAYS) begin
          c[14].m = split_m;
          c[14].d = split_d;
        end else begin
          c[14].m = p[13].tm;
          c[14].d = (p[13].d > len) ? len : p[13].d;
        end
      end
    endcase
  end

  `GDA_ASSERT_AFTER(a_reset_empty, clk, rst, !m_tvalid)
  `GDA_ASSERT_IMP(a_ok_range, clk, rst, m_tvalid && (m_tuser == ST_OK), (m_tdata[3:0] >= 4'd1) && (m_tdata[3:0] <= 4'd12) && (m_tdata[8:4] != 5'd0) && (m_tdata[22:9] != 14'd0))
  `GDA_ASSERT_IMP(a_late_date, clk, rst, m_tvalid && (m_tuser == ST_LATE), (m_tdata[3:0] == 4'd12) && (m_tdata[8:4] == 5'd31) && (m_tdata[22:9] == 14'(MAX_YEAR)))

endmodule

// File: tb/sv/gregorian_date_adder_tb.sv
// -----------------------------------------------------------------------------
// Gregorian date adder testbench
// Drives date and amount transactions through the stream ports, predicts each
// resulting date and status, and compares them in order with the outputs.
// -----------------------------------------------------------------------------
module gregorian_date_adder_tb;
  import gda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAST_YEAR = 9999;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         mon;
    logic [4:0]         day;
    logic [13:0]        yr;
    logic signed [20:0] amt;
  } date_op_t;

  typedef struct packed {
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [13:0] yr;
    status_t     st;
  } date_res_t;

  typedef struct {
    date_op_t  op;
    logic      typed;
    date_res_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  date_res_t pending_dates[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        ops_sent = 0;

  gregorian_date_adder #(.MAX_YEAR(LAST_YEAR)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in(longint m, longint y);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic longint day_number(longint m, longint d, longint y);
    longint p;
    longint n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (longint k = 1; k < m; k++) n += days_in(k, y);
    return n + d - 1;
  endfunction

  function automatic date_res_t add_to_date(date_op_t op);
    date_res_t r;
    longint m, d, y, a, n, ty, tm, t, q, rr, rem, q400, q100, q4, q1, len;
    m = op.mon;
    d = op.day;
    y = op.yr;
    a = op.amt;
    r = '{mon: 0, day: 0, yr: 0, st: ST_OK};
    if (m < 1 || m > 12 || y < 1 || y > LAST_YEAR || d < 1 || d > days_in(m, y)) begin
      r.st = ST_INVALID;
      return r;
    end
    if (op.kind == KIND_DAYS) begin
      n = day_number(m, d, y) + a;
      if (n < 0) r.st = ST_EARLY;
      else if (n > day_number(12, 31, LAST_YEAR)) r.st = ST_LATE;
      else begin
        q400 = n / 146097;
        rem = n % 146097;
        q100 = rem / 36524;
        if (q100 > 3) q100 = 3;
        rem -= q100 * 36524;
        q4 = rem / 1461;
        rem %= 1461;
        q1 = rem / 365;
        if (q1 > 3) q1 = 3;
        rem -= q1 * 365;
        ty = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        tm = 1;
        while (rem >= days_in(tm, ty) && tm < 12) begin
          rem -= days_in(tm, ty);
          tm++;
        end
        r.mon = tm;
        r.day = rem + 1;
        r.yr = ty;
      end
    end else begin
      ty = y;
      tm = m;
      if (op.kind == KIND_MONTHS) begin
        t = y * 12 + (m - 1) + a;
        q = t / 12;
        rr = t % 12;
        if (rr < 0) begin
          rr += 12;
          q--;
        end
        ty = q;
        tm = rr + 1;
      end else if (op.kind == KIND_YEARS) begin
        ty = y + a;
      end
      if (ty < 1) r.st = ST_EARLY;
      else if (ty > LAST_YEAR) r.st = ST_LATE;
      else begin
        len = days_in(tm, ty);
        r.mon = tm;
        r.yr = ty;
        r.day = (d > len) ? len : d;
      end
    end
    if (r.st == ST_EARLY) r = '{mon: 1, day: 1, yr: 1, st: ST_EARLY};
    else if (r.st == ST_LATE) r = '{mon: 12, day: 31, yr: LAST_YEAR, st: ST_LATE};
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_op(date_op_t op, date_res_t want);
    while (($urandom_range(99) < send_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, op.amt, op.yr, op.day, op.mon};
    s_tuser  <= op.kind;
    pending_dates.push_back(want);
    ops_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    date_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 1);
      end else begin
        want = pending_dates.pop_front();
        if (m_tdata[3:0] !== want.mon) report_mismatch("month", m_tdata[3:0], want.mon);
        if (m_tdata[8:4] !== want.day) report_mismatch("day", m_tdata[8:4], want.day);
        if (m_tdata[22:9] !== want.yr) report_mismatch("year", m_tdata[22:9], want.yr);
        if (m_tdata[23] !== 1'b0) report_mismatch("pad", m_tdata[23], 0);
        if (m_tuser !== want.st) report_mismatch("status", m_tuser, want.st);
      end
    end
  end

  function automatic date_op_t random_op();
    date_op_t op;
    int pick;
    op.kind = $urandom_range(99) < 4 ? KIND_NONE : 2'($urandom_range(2));
    op.yr = $urandom_range(99) < 85 ? 14'($urandom_range(LAST_YEAR, 1))
                                    : 14'($urandom);
    op.mon = $urandom_range(99) < 90 ? 4'($urandom_range(12, 1)) : 4'($urandom);
    op.day = $urandom_range(99) < 90 ? 5'($urandom_range(days_in(op.mon, op.yr) > 0 ?
                                       days_in(op.mon, op.yr) : 31, 1)) : 5'($urandom);
    pick = $urandom_range(3);
    case (pick)
      0: op.amt = 21'($signed($urandom_range(800)) - 400);
      1: op.amt = 21'($signed($urandom_range(40000)) - 20000);
      2: op.amt = 21'($signed($urandom_range(8000000)) - 4000000);
      default: op.amt = 21'($urandom);
    endcase
    if (op.kind != KIND_DAYS && pick == 1) op.amt = op.amt / 2;
    return op;
  endfunction

  row_t rows[$];

  task automatic add_row(logic [1:0] k, int mo, int dy, int yr, int am,
                         logic typed = 0, int rm = 0, int rd = 0, int ry = 0,
                         status_t st = ST_OK);
    row_t r;
    r.op = '{kind: k, mon: mo, day: dy, yr: yr, amt: am};
    r.typed = typed;
    r.res = '{mon: rm, day: rd, yr: ry, st: st};
    rows.push_back(r);
  endtask

  initial begin
    date_op_t op;
    add_row(KIND_DAYS, 1, 1, 1, 0, 1, 1, 1, 1, ST_OK);
    add_row(KIND_DAYS, 1, 1, 1, -1, 1, 1, 1, 1, ST_EARLY);
    add_row(KIND_DAYS, 12, 31, LAST_YEAR, 1, 1, 12, 31, LAST_YEAR, ST_LATE);
    add_row(KIND_DAYS, 12, 31, LAST_YEAR, 0, 1, 12, 31, LAST_YEAR, ST_OK);
    add_row(KIND_DAYS, 2, 29, 2023, 5, 1, 0, 0, 0, ST_INVALID);
    add_row(KIND_DAYS, 0, 1, 2000, 5, 1, 0, 0, 0, ST_INVALID);
    add_row(KIND_MONTHS, 15, 31, 16383, -1048576, 1, 0, 0, 0, ST_INVALID);
    add_row(KIND_YEARS, 4, 31, 2000, 1, 1, 0, 0, 0, ST_INVALID);
    add_row(KIND_YEARS, 1, 0, 0, 1, 1, 0, 0, 0, ST_INVALID);
    add_row(KIND_YEARS, 2, 29, 2000, 1, 1, 2, 28, 2001, ST_OK);
    add_row(KIND_YEARS, 5, 5, 10, -10, 1, 1, 1, 1, ST_EARLY);
    add_row(KIND_YEARS, 5, 5, 10, 1048575, 1, 12, 31, LAST_YEAR, ST_LATE);
    add_row(KIND_MONTHS, 1, 31, 2024, 1, 1, 2, 29, 2024, ST_OK);
    add_row(KIND_MONTHS, 12, 15, 2024, 12);
    add_row(KIND_MONTHS, 1, 15, 2024, -13);
    add_row(KIND_MONTHS, 3, 3, 3, -1048576, 1, 1, 1, 1, ST_EARLY);
    add_row(KIND_NONE, 7, 4, 1776, 99, 1, 7, 4, 1776, ST_OK);
    add_row(KIND_DAYS, 2, 28, 1900, 1);
    add_row(KIND_DAYS, 2, 28, 2000, 1);
    add_row(KIND_DAYS, 12, 31, 2000, 1);
    add_row(KIND_DAYS, 6, 15, 5000, 1048575);
    add_row(KIND_DAYS, 6, 15, 5000, -1048576);
    add_row(KIND_DAYS, 1, 1, 1, 146096);
    add_row(KIND_DAYS, 12, 31, 400, -365);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 47;
    foreach (rows[i]) begin
      send_op(rows[i].op, rows[i].typed ? rows[i].res : add_to_date(rows[i].op));
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 35 : 0;
      repeat (267) begin
        op = random_op();
        send_op(op, add_to_date(op));
      end
    end
    s_tvalid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d date transactions (%0d directed), checked %0d results,",
             ops_sent, rows.size(), results_seen);
    $display("covering day, month and year addition, clamping and invalid dates.");
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results outstanding", pending_dates.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
